// ----- design/wsl_pkg.sv -----
package wsl_pkg;

  // sizing of the block
  localparam int PATTERN_BYTES = 32;
  localparam int COUNT_BITS    = 16;
  localparam int POSITION_BITS = 32;

  // one cell per usable pattern byte, never more than the 32-bit match vector
  localparam int NUM_CELLS  = (PATTERN_BYTES < 32) ? PATTERN_BYTES : 32;
  localparam int CELL_IDX_W = $clog2(NUM_CELLS);
  localparam int LEN_W      = 6;

  // result field widths
  localparam int OUT_CNT_W = 16;
  localparam int OUT_OFS_W = 32;
  localparam int HINT_W    = 32;
  localparam int POS_EXT_W = (POSITION_BITS > OUT_OFS_W) ? POSITION_BITS : OUT_OFS_W;
  localparam int CNT_EXT_W = (COUNT_BITS > OUT_CNT_W) ? COUNT_BITS : OUT_CNT_W;

  // configuration port
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int PAT_W  = 256;

  typedef enum logic [2:0] {
    REG_PAT_LOW      = 3'd0,
    REG_PAT_MID_LOW  = 3'd1,
    REG_PAT_MID_HIGH = 3'd2,
    REG_PAT_HIGH     = 3'd3,
    REG_CARE_MASK    = 3'd4,
    REG_PAT_LENGTH   = 3'd5,
    REG_HINT_OFFSET  = 3'd6
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_NOT_FOUND = 2'd0,
    ST_AT_HINT   = 2'd1,
    ST_MOVED     = 2'd2,
    ST_AMBIGUOUS = 2'd3
  } status_t;

  typedef struct packed {
    logic [PAT_W-1:0]  pattern;
    logic [31:0]       care_mask;
    logic [LEN_W-1:0]  pattern_length;
    logic [HINT_W-1:0] hint_offset;
  } cfg_t;

  // shared controls of the cell row
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

  // one item between the cell row and the tally stage
  typedef struct packed {
    logic                     hit;
    logic                     at_hint;
    logic                     last;
    logic [POSITION_BITS-1:0] start;
  } hit_item_t;

endpackage

// ----- design/wsl_regs.sv -----
module wsl_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [wsl_pkg::ADDR_W-1:0] paddr,
  input  logic [wsl_pkg::DATA_W-1:0] pwdata,
  output logic [wsl_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output wsl_pkg::cfg_t              cfg
);
  import wsl_pkg::*;

  logic [63:0]       pat0_r, pat1_r, pat2_r, pat3_r;
  logic [31:0]       care_r;
  logic [LEN_W-1:0]  len_r;
  logic [HINT_W-1:0] hint_r;
  reg_idx_t          idx;
  logic              wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_t'(paddr[5:3]);
  assign wr_en  = psel && penable && pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat0_r <= '0;
      pat1_r <= '0;
      pat2_r <= '0;
      pat3_r <= '0;
      care_r <= '0;
      len_r  <= LEN_W'(1);
      hint_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_PAT_LOW:      pat0_r <= pwdata;
        REG_PAT_MID_LOW:  pat1_r <= pwdata;
        REG_PAT_MID_HIGH: pat2_r <= pwdata;
        REG_PAT_HIGH:     pat3_r <= pwdata;
        REG_CARE_MASK:    care_r <= pwdata[31:0];
        REG_PAT_LENGTH:   len_r  <= pwdata[LEN_W-1:0];
        REG_HINT_OFFSET:  hint_r <= pwdata[HINT_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    unique case (idx)
      REG_PAT_LOW:      prdata = pat0_r;
      REG_PAT_MID_LOW:  prdata = pat1_r;
      REG_PAT_MID_HIGH: prdata = pat2_r;
      REG_PAT_HIGH:     prdata = pat3_r;
      REG_CARE_MASK:    prdata = DATA_W'(care_r);
      REG_PAT_LENGTH:   prdata = DATA_W'(len_r);
      REG_HINT_OFFSET:  prdata = DATA_W'(hint_r);
      default:          prdata = '0;
    endcase
  end

  assign cfg.pattern        = {pat3_r, pat2_r, pat1_r, pat0_r};
  assign cfg.care_mask      = care_r;
  assign cfg.pattern_length = len_r;
  assign cfg.hint_offset    = hint_r;

endmodule

// ----- design/wsl_cell.sv -----
module wsl_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  wsl_pkg::cell_ctrl_t ctrl,
  input  logic [7:0]          data_byte,
  input  logic [7:0]          pat_byte,
  input  logic                care,
  input  logic                active,
  input  logic                prev_match,
  output logic                match_nxt,
  output logic                match_r
);
  import wsl_pkg::*;

  // prefix through this byte matches if the neighbor's prefix matched last byte
  assign match_nxt = active && prev_match && (!care || (data_byte == pat_byte));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else if (ctrl.shift) begin
      match_r <= ctrl.clear ? 1'b0 : match_nxt;
    end
  end

endmodule

// ----- design/wsl_tally.sv -----
module wsl_tally (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          hit_valid,
  input  wsl_pkg::hit_item_t            hit_item,
  input  logic [wsl_pkg::HINT_W-1:0]    hint_offset,
  output logic                          take,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [wsl_pkg::OUT_CNT_W-1:0] out_match_count,
  output logic [wsl_pkg::OUT_OFS_W-1:0] out_match_offset
);
  import wsl_pkg::*;

  localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

  logic [COUNT_BITS-1:0]    seen_r, seen_nxt, seen_upd;
  logic [POSITION_BITS-1:0] earliest_r, earliest_nxt, earliest_upd;
  logic                     hint_hit_r, hint_hit_nxt, hint_hit_upd;
  logic                     out_valid_r;
  status_t                  status_r, status_res;
  logic [OUT_CNT_W-1:0]     count_r, count_res;
  logic [OUT_OFS_W-1:0]     offset_r, offset_res;
  logic [CNT_EXT_W-1:0]     seen_ext;
  logic [POS_EXT_W-1:0]     earliest_ext;

  // a last item needs the result slot free or draining
  assign take = hit_valid && (!hit_item.last || !out_valid_r || out_ready);

  // fold one hit into the running totals
  always_comb begin
    seen_upd     = seen_r;
    earliest_upd = earliest_r;
    hint_hit_upd = hint_hit_r;
    if (hit_item.hit) begin
      if (seen_r == '0) begin
        earliest_upd = hit_item.start;
      end
      if (seen_r != CNT_MAX) begin
        seen_upd = seen_r + 1'b1;
      end
      if (hit_item.at_hint) begin
        hint_hit_upd = 1'b1;
      end
    end
  end

  // totals clear after the last byte of a region
  always_comb begin
    seen_nxt     = seen_r;
    earliest_nxt = earliest_r;
    hint_hit_nxt = hint_hit_r;
    if (take) begin
      if (hit_item.last) begin
        seen_nxt     = '0;
        earliest_nxt = '0;
        hint_hit_nxt = 1'b0;
      end else begin
        seen_nxt     = seen_upd;
        earliest_nxt = earliest_upd;
        hint_hit_nxt = hint_hit_upd;
      end
    end
  end

  // region outcome
  assign seen_ext     = CNT_EXT_W'(seen_upd);
  assign earliest_ext = POS_EXT_W'(earliest_upd);

  always_comb begin
    if (hint_hit_upd) begin
      status_res = ST_AT_HINT;
      count_res  = OUT_CNT_W'(1);
      offset_res = OUT_OFS_W'(hint_offset);
    end else if (seen_upd == '0) begin
      status_res = ST_NOT_FOUND;
      count_res  = '0;
      offset_res = '0;
    end else begin
      status_res = (seen_upd == COUNT_BITS'(1)) ? ST_MOVED : ST_AMBIGUOUS;
      count_res  = (seen_ext > CNT_EXT_W'({OUT_CNT_W{1'b1}})) ? {OUT_CNT_W{1'b1}}
                                                              : seen_ext[OUT_CNT_W-1:0];
      offset_res = earliest_ext[OUT_OFS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r      <= '0;
      earliest_r  <= '0;
      hint_hit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      seen_r     <= seen_nxt;
      earliest_r <= earliest_nxt;
      hint_hit_r <= hint_hit_nxt;
      if (take && hit_item.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (take && hit_item.last) begin
      status_r <= status_res;
      count_r  <= count_res;
      offset_r <= offset_res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_match_count  = count_r;
  assign out_match_offset = offset_r;

`ifndef SYNTH
  a_hint_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_AT_HINT) |-> (count_r == OUT_CNT_W'(1)))
    else $error("found-at-hint result without count of one");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && status_r == ST_NOT_FOUND) |-> (count_r == '0 && offset_r == '0))
    else $error("not-found result with nonzero count or offset");

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (take && hit_item.last) |=> (seen_r == '0 && !hint_hit_r))
    else $error("totals not cleared after region end");
`endif

endmodule

// ----- design/wildcard_signature_locator_unit.sv -----
// Wildcard byte pattern locator. Bytes of one region enter one per cycle with no
// gaps required: a row of one compare cell per pattern byte shifts its prefix-match
// bit to the next cell each time an item is taken, so the sustained rate is one
// byte per cycle while input is not stalled. A region's result passes through the
// hit stage register into an output register and waits there; input stalls only
// when another region's last byte reaches the tally stage while that result is
// still not taken. Configure pattern, care mask, length and hint over the register
// port only while no region is in flight.
module wildcard_signature_locator_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wsl_pkg::ADDR_W-1:0]    paddr,
  input  logic [wsl_pkg::DATA_W-1:0]    pwdata,
  output logic [wsl_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [wsl_pkg::OUT_CNT_W-1:0] out_match_count,
  output logic [wsl_pkg::OUT_OFS_W-1:0] out_match_offset
);
  import wsl_pkg::*;

  cfg_t                     cfg;
  cell_ctrl_t               ctrl;
  logic                     accept;
  logic [LEN_W-1:0]         eff_len, len_m1;
  logic [NUM_CELLS-1:0]     pm_r, pm_nxt, active;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, start;
  logic                     at_hint;
  logic                     s1_valid_r;
  hit_item_t                s1_r;
  logic                     take;

  wsl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // effective length: zero acts as one, large values stop at the cell count
  always_comb begin
    eff_len = cfg.pattern_length;
    if (eff_len == '0) begin
      eff_len = LEN_W'(1);
    end
    if (eff_len > LEN_W'(NUM_CELLS)) begin
      eff_len = LEN_W'(NUM_CELLS);
    end
  end
  assign len_m1 = eff_len - 1'b1;

  assign in_ready   = !s1_valid_r || take;
  assign accept     = in_valid && in_ready;
  assign ctrl.shift = accept;
  assign ctrl.clear = in_last_byte;

  // row of compare cells
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    logic prev;
    if (i == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_body
      assign prev = pm_r[i-1];
    end
    assign active[i] = (LEN_W'(i) <= len_m1);
    wsl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .data_byte  (in_data_byte),
      .pat_byte   (cfg.pattern[i*8 +: 8]),
      .care       (cfg.care_mask[i]),
      .active     (active[i]),
      .prev_match (prev),
      .match_nxt  (pm_nxt[i]),
      .match_r    (pm_r[i])
    );
  end

  // byte position and candidate start offset
  assign start   = pos_r - POSITION_BITS'(len_m1);
  assign at_hint = (POS_EXT_W'(start) == POS_EXT_W'(cfg.hint_offset));
  assign pos_nxt = in_last_byte ? '0 : pos_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        pos_r <= pos_nxt;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (take) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  // hit stage register
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r.hit     <= pm_nxt[len_m1[CELL_IDX_W-1:0]];
      s1_r.at_hint <= at_hint;
      s1_r.last    <= in_last_byte;
      s1_r.start   <= start;
    end
  end

  wsl_tally u_tally (
    .clk              (clk),
    .rst_n            (rst_n),
    .hit_valid        (s1_valid_r),
    .hit_item         (s1_r),
    .hint_offset      (cfg.hint_offset),
    .take             (take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_match_count  (out_match_count),
    .out_match_offset (out_match_offset)
  );

`ifndef SYNTH
  a_scan_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_last_byte) |=> (pos_r == '0 && pm_r == '0))
    else $error("scan state not cleared after region end");

  a_stage_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !take) |=> s1_valid_r)
    else $error("stalled hit item dropped");

  a_mid_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_r.last) |-> take)
    else $error("mid-region item stalled in tally stage");
`endif

endmodule
